// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked concurrent assertions with an async reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/tha_pkg.sv -----
// ----------------------------------------------------------------------------
// tha_pkg
// Types, widths and fixed-point constants of the temperature/humidity monitor.
// ----------------------------------------------------------------------------
package tha_pkg;

	localparam int MODE_W  = 2;
	localparam int CODE_W  = 14;
	localparam int VAL_W   = 18;
	localparam int DLY_W   = 16;
	localparam int C_W     = 19;	// humidity code in 1/256 percent, and temperature offset
	localparam int L_W     = 24;	// linearized humidity and compensation term
	localparam int SUM_W   = L_W + 1;
	localparam int OP_W    = 25;	// multiplier operand
	localparam int PROD_W  = 2 * OP_W;
	localparam int ACC_W   = 56;
	localparam int SPLIT_W = 18;	// width of the low part of a wide operand split for the multiplier
	localparam int FRAC_W  = 32;
	localparam int REG_W   = 32;
	localparam int PADDR_W = 5;
	localparam int RIDX_W  = 3;
	localparam int NFLAG   = 4;

	// Input modes
	typedef enum logic [MODE_W-1:0] {
		MODE_TEMP  = 2'd0,
		MODE_HUM   = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	// Register map (word index)
	typedef enum logic [RIDX_W-1:0] {
		REG_TEMP_ALARM = 3'd0,
		REG_TEMP_TRIP  = 3'd1,
		REG_TEMP_DELAY = 3'd2,
		REG_RH_ALARM   = 3'd3,
		REG_RH_TRIP    = 3'd4,
		REG_RH_DELAY   = 3'd5
	} reg_idx_t;

	// Flag bit positions
	localparam int FLG_TEMP_ALARM = 0;
	localparam int FLG_TEMP_TRIP  = 1;
	localparam int FLG_RH_ALARM   = 2;
	localparam int FLG_RH_TRIP    = 3;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_X1,
		ST_X2,
		ST_P1,
		ST_P2,
		ST_L1,
		ST_L2,
		ST_G1,
		ST_G2,
		ST_C1,
		ST_C2,
		ST_C3,
		ST_C4,
		ST_DONE
	} state_t;

	// Control for the shared multiply-accumulate unit
	typedef struct packed {
		logic issue;	// multiply this cycle, accumulate next cycle
		logic load;	// start from the addend instead of the accumulator
		logic shl;	// weight the product by 2^SPLIT_W
	} mac_ctl_t;

	// Conversion offsets
	localparam logic signed [VAL_W-1:0] T_OFF = 18'sd12800;	// 50 deg
	localparam logic signed [C_W-1:0]   C_OFF = 19'sd6144;	// 24 percent
	localparam logic signed [C_W-1:0]   T_REF = 19'sd7680;	// 30 deg

	// Linearization: P = (A2N*C - A1S)*C + A0N, lin = C + floor((P + 2^31) / 2^32)
	localparam logic signed [OP_W-1:0]  K_A2N = 25'sd65934;
	localparam logic signed [ACC_W-1:0] K_A1S = 56'sd1721422848;
	localparam logic signed [ACC_W-1:0] K_P0  = 56'sd22696325179;	// A0N plus one half
	// Compensation gain: G = Q1*L + Q0
	localparam logic signed [OP_W-1:0]  K_Q1   = 25'sd39762;
	localparam logic signed [ACC_W-1:0] K_Q0   = 56'sd847397048;
	localparam logic signed [ACC_W-1:0] K_HALF = 56'sd2147483648;

	localparam logic signed [SUM_W-1:0] SUM_VMAX = SUM_W'((1 <<< (VAL_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SUM_VMIN = SUM_W'(-(1 <<< (VAL_W - 1)));

	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > SUM_VMAX) begin
			r = VAL_W'(SUM_VMAX);
		end else if (v < SUM_VMIN) begin
			r = VAL_W'(SUM_VMIN);
		end else begin
			r = VAL_W'(v);
		end
		return r;
	endfunction

endpackage

// ----- sv/tha_in_if.sv -----
// ----------------------------------------------------------------------------
// tha_in_if
// Sample channel: mode and raw sensor code with valid/ready.
// ----------------------------------------------------------------------------
interface tha_in_if;
	logic                        valid;
	logic                        ready;
	logic [tha_pkg::MODE_W-1:0]  mode;
	logic [tha_pkg::CODE_W-1:0]  raw_code;

	modport source (output valid, mode, raw_code, input ready);
	modport sink   (input valid, mode, raw_code, output ready);
endinterface

// ----- sv/tha_out_if.sv -----
// ----------------------------------------------------------------------------
// tha_out_if
// Result channel: converted value and the four sticky flags with valid/ready.
// ----------------------------------------------------------------------------
interface tha_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [tha_pkg::VAL_W-1:0]  measured_value;
	logic                              temp_alarm;
	logic                              temp_trip;
	logic                              rh_alarm;
	logic                              rh_trip;

	modport source (output valid, measured_value, temp_alarm, temp_trip, rh_alarm, rh_trip,
		input ready);
	modport sink   (input valid, measured_value, temp_alarm, temp_trip, rh_alarm, rh_trip,
		output ready);
endinterface

// ----- sv/temp_humidity_alarm_monitor.sv -----
// ----------------------------------------------------------------------------
// temp_humidity_alarm_monitor
// Converts raw temperature and humidity codes, compensates humidity against
// the last temperature, and qualifies both channels against alarm and trip
// limits with sticky flags.
// ----------------------------------------------------------------------------
// Sequencing: temperature, clear and unused-mode items pass from IDLE straight
//   to DONE; a humidity item makes six passes through the one shared
//   multiplier, each product registered before it is accumulated, and every
//   item may wait in DONE until the output register is free.
// Throughput: one item at a time; the next item is taken as soon as the
//   previous result sits in the output register.
// Reset (arst_n low): flags, counts and last temperature clear, limits return
//   to 90.0 and 100.0, delays to zero; takes effect at once.
// ----------------------------------------------------------------------------
module temp_humidity_alarm_monitor (
	input  logic                              clk,
	input  logic                              arst_n,
	tha_in_if.sink                            sample,
	tha_out_if.source                         result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tha_pkg::PADDR_W-1:0]       paddr,
	input  logic [tha_pkg::REG_W-1:0]         pwdata,
	output logic [tha_pkg::REG_W-1:0]         prdata,
	output logic                              pready
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [tha_pkg::VAL_W-1:0] temp_alarm_limit_q;
	logic signed [tha_pkg::VAL_W-1:0] temp_trip_limit_q;
	logic [tha_pkg::DLY_W-1:0]        temp_delay_q;
	logic signed [tha_pkg::VAL_W-1:0] rh_alarm_limit_q;
	logic signed [tha_pkg::VAL_W-1:0] rh_trip_limit_q;
	logic [tha_pkg::DLY_W-1:0]        rh_delay_q;
	logic                             cfg_wr;
	logic [tha_pkg::RIDX_W-1:0]       cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[tha_pkg::PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_alarm_limit_q <= 18'sd23040;
			temp_trip_limit_q  <= 18'sd25600;
			temp_delay_q       <= '0;
			rh_alarm_limit_q   <= 18'sd23040;
			rh_trip_limit_q    <= 18'sd25600;
			rh_delay_q         <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				tha_pkg::REG_TEMP_ALARM: temp_alarm_limit_q <= pwdata[tha_pkg::VAL_W-1:0];
				tha_pkg::REG_TEMP_TRIP:  temp_trip_limit_q  <= pwdata[tha_pkg::VAL_W-1:0];
				tha_pkg::REG_TEMP_DELAY: temp_delay_q       <= pwdata[tha_pkg::DLY_W-1:0];
				tha_pkg::REG_RH_ALARM:   rh_alarm_limit_q   <= pwdata[tha_pkg::VAL_W-1:0];
				tha_pkg::REG_RH_TRIP:    rh_trip_limit_q    <= pwdata[tha_pkg::VAL_W-1:0];
				tha_pkg::REG_RH_DELAY:   rh_delay_q         <= pwdata[tha_pkg::DLY_W-1:0];
				default: ;	// drop writes beyond the map
			endcase
		end
	end

	// read back: limits sign-extended, delays zero-extended
	always_comb begin
		case (cfg_idx)
			tha_pkg::REG_TEMP_ALARM: prdata = tha_pkg::REG_W'(temp_alarm_limit_q);
			tha_pkg::REG_TEMP_TRIP:  prdata = tha_pkg::REG_W'(temp_trip_limit_q);
			tha_pkg::REG_TEMP_DELAY: prdata = tha_pkg::REG_W'(temp_delay_q);
			tha_pkg::REG_RH_ALARM:   prdata = tha_pkg::REG_W'(rh_alarm_limit_q);
			tha_pkg::REG_RH_TRIP:    prdata = tha_pkg::REG_W'(rh_trip_limit_q);
			tha_pkg::REG_RH_DELAY:   prdata = tha_pkg::REG_W'(rh_delay_q);
			default:                 prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Item registers
	// ------------------------------------------------------------------
	tha_pkg::state_t                  state_q, state_d;
	logic                             in_acc;
	logic                             smp_ready;
	logic                             fire;
	logic [tha_pkg::MODE_W-1:0]       mode_q;
	logic signed [tha_pkg::C_W-1:0]   c_in;
	logic signed [tha_pkg::C_W-1:0]   c_q;
	logic signed [tha_pkg::VAL_W-1:0] t_in;
	logic signed [tha_pkg::VAL_W-1:0] val_q;
	logic signed [tha_pkg::L_W-1:0]   l_q;
	logic signed [tha_pkg::VAL_W-1:0] last_temp_q;
	logic [tha_pkg::NFLAG-1:0]        flags_q;
	logic [tha_pkg::NFLAG-1:0]        flags_d;

	// temperature: code*8 - 50 deg; humidity: code*16 - 24 percent
	assign t_in = $signed({1'b0, sample.raw_code, 3'b000}) - tha_pkg::T_OFF;
	assign c_in = $signed({1'b0, sample.raw_code, 4'b0000}) - tha_pkg::C_OFF;

	assign smp_ready    = (state_q == tha_pkg::ST_IDLE);
	assign sample.ready = smp_ready;
	assign in_acc       = sample.valid && smp_ready;

	// ------------------------------------------------------------------
	// Shared multiply-accumulate unit and its operand selection
	// ------------------------------------------------------------------
	tha_pkg::mac_ctl_t                 mac_ctl;
	logic signed [tha_pkg::OP_W-1:0]   mac_a;
	logic signed [tha_pkg::OP_W-1:0]   mac_b;
	logic signed [tha_pkg::ACC_W-1:0]  mac_add;
	logic signed [tha_pkg::ACC_W-1:0]  acc;
	logic signed [tha_pkg::OP_W-1:0]   acc_hi;
	logic signed [tha_pkg::OP_W-1:0]   acc_lo;
	logic signed [tha_pkg::C_W-1:0]    dt;
	logic signed [tha_pkg::L_W-1:0]    l_d;
	logic signed [tha_pkg::L_W-1:0]    comp;
	logic signed [tha_pkg::SUM_W-1:0]  sum;

	tha_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (mac_a),
		.b      (mac_b),
		.addend (mac_add),
		.acc    (acc)
	);

	// split a wide accumulator value into a signed high part and an unsigned
	// low part so each fits the multiplier
	assign acc_hi = tha_pkg::OP_W'(acc >>> tha_pkg::SPLIT_W);
	assign acc_lo = tha_pkg::OP_W'($signed({1'b0, acc[tha_pkg::SPLIT_W-1:0]}));

	// temperature offset from 30 deg for compensation
	assign dt = tha_pkg::C_W'(last_temp_q) - tha_pkg::T_REF;

	// linearized humidity, rounded to 1/256 percent
	assign l_d  = tha_pkg::L_W'(c_q) + tha_pkg::L_W'(acc >>> tha_pkg::FRAC_W);
	// compensation term, rounded to 1/256 percent
	assign comp = tha_pkg::L_W'(acc >>> tha_pkg::FRAC_W);
	assign sum  = tha_pkg::SUM_W'(l_q) + tha_pkg::SUM_W'(comp);

	// ------------------------------------------------------------------
	// Sequencer
	//   X1      issue A2N*C, load -A1S          -> X
	//   P1, P2  issue Xhi*C (shifted, load P0), Xlo*C
	//   L2      take L = C + round(acc / 2^32)
	//   G1      issue Q1*L, load Q0             -> G
	//   C1, C2  issue Ghi*dT (shifted, load half), Glo*dT
	//   C4      saturate L + comp
	//   X2, L1, G2, C3 wait for the accumulator
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tha_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mac_ctl = '0;
		mac_a   = '0;
		mac_b   = '0;
		mac_add = '0;
		fire    = 1'b0;
		case (state_q)
			tha_pkg::ST_IDLE: begin
				if (sample.valid) begin
					state_d = (sample.mode == tha_pkg::MODE_HUM) ? tha_pkg::ST_X1
					                                             : tha_pkg::ST_DONE;
				end
			end
			tha_pkg::ST_X1: begin
				mac_ctl = '{issue: 1'b1, load: 1'b1, shl: 1'b0};
				mac_a   = tha_pkg::OP_W'(c_q);
				mac_b   = tha_pkg::K_A2N;
				mac_add = -tha_pkg::K_A1S;
				state_d = tha_pkg::ST_X2;
			end
			tha_pkg::ST_X2: state_d = tha_pkg::ST_P1;
			tha_pkg::ST_P1: begin
				mac_ctl = '{issue: 1'b1, load: 1'b1, shl: 1'b1};
				mac_a   = acc_hi;
				mac_b   = tha_pkg::OP_W'(c_q);
				mac_add = tha_pkg::K_P0;
				state_d = tha_pkg::ST_P2;
			end
			tha_pkg::ST_P2: begin
				mac_ctl = '{issue: 1'b1, load: 1'b0, shl: 1'b0};
				mac_a   = acc_lo;
				mac_b   = tha_pkg::OP_W'(c_q);
				state_d = tha_pkg::ST_L1;
			end
			tha_pkg::ST_L1: state_d = tha_pkg::ST_L2;
			tha_pkg::ST_L2: state_d = tha_pkg::ST_G1;
			tha_pkg::ST_G1: begin
				mac_ctl = '{issue: 1'b1, load: 1'b1, shl: 1'b0};
				mac_a   = tha_pkg::OP_W'(l_q);
				mac_b   = tha_pkg::K_Q1;
				mac_add = tha_pkg::K_Q0;
				state_d = tha_pkg::ST_G2;
			end
			tha_pkg::ST_G2: state_d = tha_pkg::ST_C1;
			tha_pkg::ST_C1: begin
				mac_ctl = '{issue: 1'b1, load: 1'b1, shl: 1'b1};
				mac_a   = acc_hi;
				mac_b   = tha_pkg::OP_W'(dt);
				mac_add = tha_pkg::K_HALF;
				state_d = tha_pkg::ST_C2;
			end
			tha_pkg::ST_C2: begin
				mac_ctl = '{issue: 1'b1, load: 1'b0, shl: 1'b0};
				mac_a   = acc_lo;
				mac_b   = tha_pkg::OP_W'(dt);
				state_d = tha_pkg::ST_C3;
			end
			tha_pkg::ST_C3: state_d = tha_pkg::ST_C4;
			tha_pkg::ST_C4: state_d = tha_pkg::ST_DONE;
			tha_pkg::ST_DONE: begin
				// hold until the output register is free
				if (!result.valid || result.ready) begin
					fire    = 1'b1;
					state_d = tha_pkg::ST_IDLE;
				end
			end
			default: state_d = tha_pkg::ST_IDLE;
		endcase
	end

	// item payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= sample.mode;
			c_q    <= c_in;
			val_q  <= (sample.mode == tha_pkg::MODE_TEMP) ? t_in : '0;
		end else if (state_q == tha_pkg::ST_C4) begin
			val_q  <= tha_pkg::sat_val(sum);
		end
		if (state_q == tha_pkg::ST_L2) begin
			l_q <= l_d;
		end
	end

	// ------------------------------------------------------------------
	// Qualifiers and sticky flags
	// ------------------------------------------------------------------
	logic upd_temp;
	logic upd_rh;
	logic ta_hit, tt_hit, ra_hit, rt_hit;

	assign upd_temp = fire && (mode_q == tha_pkg::MODE_TEMP);
	assign upd_rh   = fire && (mode_q == tha_pkg::MODE_HUM);

	tha_qual u_qual_ta (
		.clk(clk), .arst_n(arst_n), .en(upd_temp), .value(val_q),
		.limit(temp_alarm_limit_q), .delay(temp_delay_q), .hit(ta_hit)
	);
	tha_qual u_qual_tt (
		.clk(clk), .arst_n(arst_n), .en(upd_temp), .value(val_q),
		.limit(temp_trip_limit_q), .delay(temp_delay_q), .hit(tt_hit)
	);
	tha_qual u_qual_ra (
		.clk(clk), .arst_n(arst_n), .en(upd_rh), .value(val_q),
		.limit(rh_alarm_limit_q), .delay(rh_delay_q), .hit(ra_hit)
	);
	tha_qual u_qual_rt (
		.clk(clk), .arst_n(arst_n), .en(upd_rh), .value(val_q),
		.limit(rh_trip_limit_q), .delay(rh_delay_q), .hit(rt_hit)
	);

	always_comb begin
		flags_d = flags_q;
		case (mode_q)
			tha_pkg::MODE_TEMP: begin
				flags_d[tha_pkg::FLG_TEMP_ALARM] = flags_q[tha_pkg::FLG_TEMP_ALARM] | ta_hit;
				flags_d[tha_pkg::FLG_TEMP_TRIP]  = flags_q[tha_pkg::FLG_TEMP_TRIP]  | tt_hit;
			end
			tha_pkg::MODE_HUM: begin
				flags_d[tha_pkg::FLG_RH_ALARM] = flags_q[tha_pkg::FLG_RH_ALARM] | ra_hit;
				flags_d[tha_pkg::FLG_RH_TRIP]  = flags_q[tha_pkg::FLG_RH_TRIP]  | rt_hit;
			end
			tha_pkg::MODE_CLEAR: flags_d = '0;
			default: ;	// unused mode: report flags as they stand
		endcase
	end

	// ------------------------------------------------------------------
	// State update and output register
	// ------------------------------------------------------------------
	logic                             out_valid_q;
	logic signed [tha_pkg::VAL_W-1:0] out_val_q;
	logic [tha_pkg::NFLAG-1:0]        out_flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_temp_q <= '0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
			out_val_q   <= '0;
			out_flags_q <= '0;
		end else begin
			if (fire) begin
				flags_q     <= flags_d;
				out_val_q   <= val_q;
				out_flags_q <= flags_d;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (upd_temp) begin
				last_temp_q <= val_q;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.measured_value = out_val_q;
	assign result.temp_alarm     = out_flags_q[tha_pkg::FLG_TEMP_ALARM];
	assign result.temp_trip      = out_flags_q[tha_pkg::FLG_TEMP_TRIP];
	assign result.rh_alarm       = out_flags_q[tha_pkg::FLG_RH_ALARM];
	assign result.rh_trip        = out_flags_q[tha_pkg::FLG_RH_TRIP];

endmodule

// ----- sv/tha_mac.sv -----
// ----------------------------------------------------------------------------
// tha_mac
// Shared signed multiplier with a registered product and a wide accumulator.
// ----------------------------------------------------------------------------
module tha_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tha_pkg::mac_ctl_t                   ctl,
	input  logic signed [tha_pkg::OP_W-1:0]     a,
	input  logic signed [tha_pkg::OP_W-1:0]     b,
	input  logic signed [tha_pkg::ACC_W-1:0]    addend,
	output logic signed [tha_pkg::ACC_W-1:0]    acc
);

	logic signed [tha_pkg::PROD_W-1:0] prod;
	logic signed [tha_pkg::PROD_W-1:0] prod_s1;
	logic signed [tha_pkg::ACC_W-1:0]  add_s1;
	tha_pkg::mac_ctl_t                 ctl_s1;
	logic signed [tha_pkg::ACC_W-1:0]  term;
	logic signed [tha_pkg::ACC_W-1:0]  base;
	logic signed [tha_pkg::ACC_W-1:0]  acc_q;

	assign prod = a * b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		add_s1  <= addend;
	end

	always_comb begin
		term = ctl_s1.shl ? (tha_pkg::ACC_W'(prod_s1) <<< tha_pkg::SPLIT_W)
		                  : tha_pkg::ACC_W'(prod_s1);
		base = ctl_s1.load ? add_s1 : acc_q;
	end

	// accumulate the registered product in the cycle after issue
	always_ff @(posedge clk) begin
		if (ctl_s1.issue) begin
			acc_q <= base + term;
		end
	end

	assign acc = acc_q;

endmodule

// ----- sv/tha_qual.sv -----
// ----------------------------------------------------------------------------
// tha_qual
// Over-limit qualifier: counts consecutive samples above a limit and fires
// once the count has reached the delay.
// ----------------------------------------------------------------------------
module tha_qual (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic signed [tha_pkg::VAL_W-1:0]    value,
	input  logic signed [tha_pkg::VAL_W-1:0]    limit,
	input  logic [tha_pkg::DLY_W-1:0]           delay,
	output logic                                hit
);

	logic                        over;
	logic                        waiting;
	logic [tha_pkg::DLY_W-1:0]   count_q;

	assign over    = value > limit;
	assign waiting = count_q < delay;
	assign hit     = en && over && !waiting;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			if (over && waiting) begin
				count_q <= count_q + tha_pkg::DLY_W'(1);
			end else begin
				count_q <= '0;
			end
		end
	end

endmodule

// ----- sv/tha_checker.sv -----
// ----------------------------------------------------------------------------
// tha_checker
// Port-level checks on the monitor: one item in flight, stalled results hold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tha_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              smp_valid,
	input logic                              smp_ready,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic signed [tha_pkg::VAL_W-1:0]  res_value,
	input logic [tha_pkg::NFLAG-1:0]         res_flags
);

	logic smp_acc;

	assign smp_acc = smp_valid && smp_ready;

	// work on one item at a time
	`TH_ASSERT_NXT(a_one_item, clk, arst_n, smp_acc, !smp_ready, "ready after accepting an item")

	// a result only appears after the block has been busy
	`TH_ASSERT_IMP(a_res_after_busy, clk, arst_n, $rose(res_valid), $past(!smp_ready), "result without work")

	// a stalled result holds its payload
	`TH_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_value) && $stable(res_flags), "stalled result changed")

	// the reported flags change only together with a new result
	`TH_ASSERT_IMP(a_flags_with_res, clk, arst_n, !$stable(res_flags), res_valid, "flags changed with no result")

endmodule

bind temp_humidity_alarm_monitor tha_checker u_tha_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.smp_valid (sample.valid),
	.smp_ready (sample.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_value (result.measured_value),
	.res_flags ({result.rh_trip, result.rh_alarm, result.temp_trip, result.temp_alarm})
);

// ----- bench/tha_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tha_result_checker
// Watches the sample, result and register ports of the monitor. Keeps its own
// copy of the limits, qualifier counts and flags. Predicts each reading and
// compares it, field by field, against the result stream in order.
// ----------------------------------------------------------------------------
module tha_result_checker
	import tha_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	tha_in_if                  sample,
	tha_out_if                 result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]   pwdata,
	output int                 fail_count,
	output int                 pending,
	output int                 results_seen
);

	localparam longint TEMP_OFFSET = 12800;
	localparam longint HUM_OFFSET  = 6144;
	localparam longint TEMP_REF    = 7680;
	localparam longint LIN_A2      = -64'sd65934;
	localparam longint LIN_A1      = 64'sd6724308;
	localparam longint LIN_A0      = -64'sd20548841531;
	localparam longint GAIN_Q1     = 64'sd39762;
	localparam longint GAIN_Q0     = 64'sd847397048;
	localparam longint FRAC_ONE    = 64'sd4294967296;
	localparam longint FRAC_HALF   = 64'sd2147483648;
	localparam longint VAL_MAX     = (longint'(1) <<< (VAL_W - 1)) - 1;
	localparam longint VAL_MIN     = -(longint'(1) <<< (VAL_W - 1));

	localparam logic signed [VAL_W-1:0] ALARM_LIMIT_RST = 18'sd23040;
	localparam logic signed [VAL_W-1:0] TRIP_LIMIT_RST  = 18'sd25600;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [NFLAG-1:0]        flags;
	} reading_t;

	logic signed [VAL_W-1:0] limit_q [NFLAG];
	logic [DLY_W-1:0]        run_len [NFLAG];
	logic [DLY_W-1:0]        temp_dly;
	logic [DLY_W-1:0]        rh_dly;
	logic [NFLAG-1:0]        flags_q;
	longint                  last_temp;
	reading_t                expected_readings [$];
	int                      errors = 0;
	int                      seen = 0;
	string                   flag_name [NFLAG] = '{"temp_alarm", "temp_trip", "rh_alarm",
		"rh_trip"};

	task automatic report_mismatch(input string what, input logic signed [VAL_W-1:0] got,
		input logic signed [VAL_W-1:0] want);
		$display("%0t: result %0d: %s is %0d, expected %0d", $time, seen, what, got, want);
		errors++;
	endtask

	// Count a consecutive over-limit run; set the sticky flag once it passes the delay.
	function automatic void qualify(input longint v, input int bit_idx,
		input logic [DLY_W-1:0] dly);
		if (v > longint'(limit_q[bit_idx])) begin
			if (run_len[bit_idx] < dly) begin
				run_len[bit_idx] = run_len[bit_idx] + 1'b1;
			end else begin
				run_len[bit_idx] = '0;
				flags_q[bit_idx] = 1'b1;
			end
		end else begin
			run_len[bit_idx] = '0;
		end
	endfunction

	function automatic reading_t convert_sample(input logic [MODE_W-1:0] m,
		input logic [CODE_W-1:0] code);
		longint   hum;
		longint   poly;
		longint   lin;
		longint   gain;
		longint   comp;
		longint   v;
		reading_t r;
		v = 0;
		case (m)
			MODE_TEMP: begin
				v = longint'(code) * 8 - TEMP_OFFSET;
				last_temp = v;
				qualify(v, FLG_TEMP_ALARM, temp_dly);
				qualify(v, FLG_TEMP_TRIP, temp_dly);
			end
			MODE_HUM: begin
				hum  = longint'(code) * 16 - HUM_OFFSET;
				poly = LIN_A2 * hum * hum + LIN_A1 * hum * 256 + LIN_A0;
				lin  = (hum * FRAC_ONE - poly + FRAC_HALF) >>> FRAC_W;
				gain = GAIN_Q1 * lin + GAIN_Q0;
				comp = ((last_temp - TEMP_REF) * gain + FRAC_HALF) >>> FRAC_W;
				v    = lin + comp;
				if (v > VAL_MAX) begin
					v = VAL_MAX;
				end else if (v < VAL_MIN) begin
					v = VAL_MIN;
				end
				qualify(v, FLG_RH_ALARM, rh_dly);
				qualify(v, FLG_RH_TRIP, rh_dly);
			end
			MODE_CLEAR: begin
				flags_q = '0;
			end
			default: begin
			end
		endcase
		r.value = VAL_W'(v);
		r.flags = flags_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		reading_t         want;
		logic [NFLAG-1:0] got_flags;
		int               i;
		if (!arst_n) begin
			limit_q[FLG_TEMP_ALARM] = ALARM_LIMIT_RST;
			limit_q[FLG_TEMP_TRIP]  = TRIP_LIMIT_RST;
			limit_q[FLG_RH_ALARM]   = ALARM_LIMIT_RST;
			limit_q[FLG_RH_TRIP]    = TRIP_LIMIT_RST;
			run_len   = '{default: '0};
			temp_dly  = '0;
			rh_dly    = '0;
			flags_q   = '0;
			last_temp = 0;
			expected_readings.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_TEMP_ALARM: limit_q[FLG_TEMP_ALARM] = pwdata[VAL_W-1:0];
					REG_TEMP_TRIP:  limit_q[FLG_TEMP_TRIP]  = pwdata[VAL_W-1:0];
					REG_TEMP_DELAY: temp_dly                = pwdata[DLY_W-1:0];
					REG_RH_ALARM:   limit_q[FLG_RH_ALARM]   = pwdata[VAL_W-1:0];
					REG_RH_TRIP:    limit_q[FLG_RH_TRIP]    = pwdata[VAL_W-1:0];
					REG_RH_DELAY:   rh_dly                  = pwdata[DLY_W-1:0];
					default: begin
					end
				endcase
			end
			if (result.valid && result.ready) begin
				got_flags = {result.rh_trip, result.rh_alarm, result.temp_trip,
					result.temp_alarm};
				if (expected_readings.size() == 0) begin
					report_mismatch("unrequested result, measured_value",
						result.measured_value, '0);
				end else begin
					want = expected_readings.pop_front();
					if (result.measured_value !== want.value) begin
						report_mismatch("measured_value", result.measured_value, want.value);
					end
					for (i = 0; i < NFLAG; i++) begin
						if (got_flags[i] !== want.flags[i]) begin
							report_mismatch(flag_name[i], got_flags[i], want.flags[i]);
						end
					end
				end
				seen++;
			end
			if (sample.valid && sample.ready) begin
				expected_readings.push_back(convert_sample(sample.mode, sample.raw_code));
			end
		end
		pending      <= expected_readings.size();
		results_seen <= seen;
		fail_count   <= errors;
	end

endmodule

// ----- bench/tb_temp_humidity_alarm_monitor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_temp_humidity_alarm_monitor
// Drives temperature, humidity, clear and unused-mode items into the monitor
// and programs its limits and delays over the register port. A checker beside
// the block predicts every reading and flag; this top makes the stimulus,
// shapes the idling on both channels and gives the verdict.
// ----------------------------------------------------------------------------
module tb_temp_humidity_alarm_monitor;
	import tha_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 12;
	localparam int ITEMS_PER_BLOCK = 103;
	localparam int NUM_BLOCKS      = 9;
	localparam int MAX_GAP         = 20;
	localparam int RX_HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT     = 4000;
	localparam int TAIL_CYCLES     = 32;
	localparam int CODE_MAX        = (1 << CODE_W) - 1;
	localparam int LIMIT_MIN       = -(1 << (VAL_W - 1));
	localparam int LIMIT_MAX       = (1 << (VAL_W - 1)) - 1;
	localparam int DELAY_MAX       = (1 << DLY_W) - 1;

	// Mode 3 has no meaning in the block; it must leave everything as it stands.
	localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;
	// Register slots past the end of the map; writes there must be dropped.
	localparam logic [RIDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [RIDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [REG_W-1:0]   pwdata;
	logic [REG_W-1:0]   prdata;
	logic               pready;

	tha_in_if  sample_ch ();
	tha_out_if result_ch ();

	int fail_count;
	int pending;
	int results_seen;

	// Idling shape: the sender's chance of a gap and the receiver's chance of a stall.
	int   tx_idle_pct;
	int   rx_idle_pct;
	int   hold_requests;
	logic rx_hold;
	int   idle_cycles = 0;
	int   sent_by_mode [4] = '{default: 0};
	int   reg_writes = 0;
	int   settings = 1;

	always #(CLK_PERIOD / 2) clk = ~clk;

	temp_humidity_alarm_monitor u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	tha_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample_ch),
		.result       (result_ch),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen)
	);

	// Receiver: stall at random, and drop ready entirely while a long hold-off runs.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Long receiver hold-off, counted here so the sender keeps offering items meanwhile
	// and the block has to back up and stall its input.
	initial begin : rx_hold_ctl
		int served;
		served  = 0;
		rx_hold = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != served) begin
				served = hold_requests;
				rx_hold <= 1'b1;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		end
	end

	// Watchdog: end the run if no handshake of any kind completes for too long.
	always @(posedge clk) begin
		if (!arst_n || (sample_ch.valid && sample_ch.ready) ||
			(result_ch.valid && result_ch.ready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d readings outstanding",
				idle_cycles, pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Offer one item after a random gap; hold valid high into the next item when no
	// gap follows, so back-to-back items never see valid drop.
	task automatic send_sample(input logic [MODE_W-1:0] m, input logic [CODE_W-1:0] code);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) begin
			gap++;
		end
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid    <= 1'b1;
		sample_ch.mode     <= m;
		sample_ch.raw_code <= code;
		do @(posedge clk); while (!sample_ch.ready);
		sent_by_mode[m]++;
	endtask

	// Drop valid and wait until every predicted reading has come back.
	task automatic settle();
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Setup then access phase; bits above the register's width carry random junk,
	// which the block must ignore.
	task automatic write_reg(input logic [RIDX_W-1:0] idx, input int value, input int width);
		logic [REG_W-1:0] mask;
		mask = (REG_W'(1) << width) - 1'b1;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= ($urandom & ~mask) | (REG_W'(value) & mask);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	// Mostly short delays so flags actually set; now and then a long one.
	function automatic int pick_delay();
		int roll;
		roll = $urandom_range(9);
		if (roll < 8) begin
			return $urandom_range(4);
		end else if (roll == 8) begin
			return $urandom_range(300);
		end
		return $urandom_range(DELAY_MAX);
	endfunction

	initial begin : stimulus
		int                blk;
		int                n;
		int                burst_left;
		int                center;
		int                spread;
		int                pick;
		int                code;
		int                t_alarm_lim;
		int                t_trip_lim;
		logic [MODE_W-1:0] burst_mode;
		logic [MODE_W-1:0] m;

		// Every input known from time zero.
		sample_ch.valid    = 1'b0;
		sample_ch.mode     = MODE_TEMP;
		sample_ch.raw_code = '0;
		result_ch.ready    = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		tx_idle_pct        = 21;
		rx_idle_pct        = 69;
		hold_requests      = 0;
		t_alarm_lim        = 23040;
		t_trip_lim         = 25600;
		burst_mode         = MODE_TEMP;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings: alarm at 90.0, trip at 100.0, no delay.
		send_sample(MODE_HUM, 14'd2048);	// humidity before any temperature
		send_sample(MODE_TEMP, 14'd0);		// coldest code
		send_sample(MODE_TEMP, CODE_MAX);	// hottest code: alarm and trip at once
		send_sample(MODE_HUM, 14'd0);
		send_sample(MODE_HUM, 14'd4095);	// top of the 12-bit humidity range
		send_sample(MODE_HUM, 14'd4096);	// first code past 12 bits
		send_sample(MODE_HUM, CODE_MAX);	// saturates high, sets both humidity flags
		send_sample(MODE_SPARE, CODE_MAX);	// unused mode reports flags untouched
		send_sample(MODE_CLEAR, 14'd0);
		send_sample(MODE_TEMP, 14'd4480);	// exactly at the alarm limit: not over
		send_sample(MODE_TEMP, 14'd4481);	// one step over the alarm limit
		send_sample(MODE_TEMP, 14'd4800);	// exactly at the trip limit
		send_sample(MODE_CLEAR, 14'd5461);
		send_sample(MODE_SPARE, 14'd0);

		// Pause the sender until everything is back, then add qualifier delays.
		settle();
		write_reg(REG_TEMP_DELAY, 2, DLY_W);
		write_reg(REG_RH_DELAY, 1, DLY_W);
		write_reg(REG_SPARE_LO, LIMIT_MIN, VAL_W);	// must not land anywhere
		write_reg(REG_SPARE_HI, 0, VAL_W);
		settings++;

		// Temperature alarm needs three over-limit items in a row with delay 2.
		repeat (4) send_sample(MODE_TEMP, 14'd5000);
		send_sample(MODE_TEMP, 14'd0);		// back under: run length restarts
		send_sample(MODE_CLEAR, CODE_MAX);	// clear ignores the code
		repeat (3) send_sample(MODE_HUM, 14'd4095);
		send_sample(MODE_HUM, 14'd0);

		// Random part: blocks of bursts, each block under fresh register settings.
		for (blk = 0; blk < NUM_BLOCKS; blk++) begin
			settle();
			if (blk == 3) begin
				tx_idle_pct = 69;
				rx_idle_pct <= 21;
			end else if (blk == 6) begin
				tx_idle_pct = 0;
				rx_idle_pct <= 0;
			end

			// Limits and delays: two blocks sit at the extremes, the rest are random.
			if (blk == 3) begin
				t_alarm_lim = LIMIT_MIN;
				t_trip_lim  = LIMIT_MAX;
				write_reg(REG_TEMP_DELAY, 0, DLY_W);
				write_reg(REG_RH_ALARM, LIMIT_MAX, VAL_W);
				write_reg(REG_RH_TRIP, LIMIT_MIN, VAL_W);
				write_reg(REG_RH_DELAY, DELAY_MAX, DLY_W);
			end else if (blk == 7) begin
				t_alarm_lim = LIMIT_MAX;
				t_trip_lim  = LIMIT_MIN;
				write_reg(REG_TEMP_DELAY, DELAY_MAX, DLY_W);
				write_reg(REG_RH_ALARM, LIMIT_MIN, VAL_W);
				write_reg(REG_RH_TRIP, LIMIT_MAX, VAL_W);
				write_reg(REG_RH_DELAY, 0, DLY_W);
			end else begin
				t_alarm_lim = int'($urandom_range(131064)) - int'(T_OFF);
				t_trip_lim  = int'($urandom_range(131064)) - int'(T_OFF);
				write_reg(REG_TEMP_DELAY, pick_delay(), DLY_W);
				write_reg(REG_RH_ALARM, int'($urandom_range(134071)) - 3000, VAL_W);
				write_reg(REG_RH_TRIP, int'($urandom_range(134071)) - 3000, VAL_W);
				write_reg(REG_RH_DELAY, pick_delay(), DLY_W);
			end
			write_reg(REG_TEMP_ALARM, t_alarm_lim, VAL_W);
			write_reg(REG_TEMP_TRIP, t_trip_lim, VAL_W);
			settings++;

			burst_left = 0;
			for (n = 0; n < ITEMS_PER_BLOCK; n++) begin
				// Once, with no idling otherwise, hold the receiver off for a long stretch.
				if (blk == 6 && n == 40) begin
					hold_requests <= hold_requests + 1;
				end

				if (burst_left == 0) begin
					pick = $urandom_range(99);
					if (pick < 8) begin
						m    = MODE_CLEAR;
						code = $urandom_range(CODE_MAX);
					end else if (pick < 10) begin
						m    = MODE_SPARE;
						code = $urandom_range(CODE_MAX);
					end else begin
						// Start a run of one channel with codes clustered around a center,
						// so qualifier counts climb and reset.
						burst_mode = (pick < 55) ? MODE_TEMP : MODE_HUM;
						burst_left = $urandom_range(8, 1);
						spread     = ($urandom_range(4) == 0) ? 2000 : 4;
						if (burst_mode == MODE_TEMP) begin
							case ($urandom_range(2))
								0:       center = (t_alarm_lim + int'(T_OFF)) / 8;
								1:       center = (t_trip_lim + int'(T_OFF)) / 8;
								default: center = $urandom_range(CODE_MAX);
							endcase
						end else begin
							center = ($urandom_range(9) < 7) ? int'($urandom_range(4095)) :
								int'($urandom_range(CODE_MAX));
						end
					end
				end
				if (burst_left != 0) begin
					m    = burst_mode;
					code = center + int'($urandom_range(2 * spread)) - spread;
					if (code < 0) begin
						code = 0;
					end else if (code > CODE_MAX) begin
						code = CODE_MAX;
					end
					burst_left--;
				end
				send_sample(m, CODE_W'(code));
			end
		end

		// Drain, then give stray results a chance to show up.
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d temperature, %0d humidity, %0d clear and %0d unused-mode items;",
			sent_by_mode[MODE_TEMP], sent_by_mode[MODE_HUM], sent_by_mode[MODE_CLEAR],
			sent_by_mode[MODE_SPARE]);
		$display("%0d readings checked over %0d register writes in %0d settings, extremes included.",
			results_seen, reg_writes, settings);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
